[sv/bra_pkg.sv]
// Shared constants for the bitmap run allocator: field widths, request kinds,
// status codes, register indexes and parameter defaults. No dependencies.
package bra_pkg;

  localparam int MAP_BITS_DEF  = 4096;
  localparam int MAX_RUN_DEF   = 8;
  localparam int WORD_BITS_DEF = 32;

  localparam int KIND_W     = 2;
  localparam int INDEX_W    = 12;
  localparam int RUN_W      = 4;
  localparam int STATUS_W   = 2;
  localparam int TOTAL_W    = 13;
  localparam int START_W    = 12;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TEST  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_MARK  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_BITS   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_START = 1'd1;

  localparam logic [TOTAL_W-1:0] TOTAL_BITS_RST   = 13'd4096;
  localparam logic [START_W-1:0] SEARCH_START_RST = 12'd0;

endpackage

[sv/bra_store.sv]
// Bitmap word store: one write port, one read port, registered read data.
// No package dependencies.
module bra_store #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 32,
  parameter int AW    = 7
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[sv/bra_scan.sv]
// Word scanner: free bits of one bitmap word that lie inside the search
// window, and their count. Depends on bra_pkg.
module bra_scan import bra_pkg::*; #(
  parameter  int WORD_BITS = WORD_BITS_DEF,
  localparam int CNT_W     = $clog2(WORD_BITS + 1)
) (
  input  logic [WORD_BITS-1:0] word,
  input  logic [TOTAL_W:0]     base,
  input  logic [START_W-1:0]   start,
  input  logic [TOTAL_W-1:0]   size,
  output logic [WORD_BITS-1:0] free_mask,
  output logic [CNT_W-1:0]     free_cnt
);

  localparam int WB_LG = $clog2(WORD_BITS);
  localparam int OFF_W = WB_LG + 1;

  logic [TOTAL_W:0] sbase;
  logic [TOTAL_W:0] diff;
  logic [OFF_W-1:0] lo_off;
  logic [OFF_W-1:0] hi_off;

  always_comb begin
    sbase  = ((TOTAL_W + 1)'(start) >> WB_LG) << WB_LG;
    lo_off = (base == sbase) ? OFF_W'(start[WB_LG-1:0]) : '0;
    diff   = {1'b0, size} - base;
    // last word of the window is cut at the size
    hi_off = (diff >= (TOTAL_W + 1)'(WORD_BITS)) ? OFF_W'(WORD_BITS) : diff[OFF_W-1:0];
    for (int j = 0; j < WORD_BITS; j++) begin
      free_mask[j] = !word[j] && (OFF_W'(j) >= lo_off) && (OFF_W'(j) < hi_off);
    end
    free_cnt = CNT_W'($countones(free_mask));
  end

endmodule

[sv/bitmap_run_allocator_core.sv]
// Bitmap run allocator, top level: request sequencer around the word store.
// Depends on bra_pkg, bra_store and bra_scan.
// Out of range, bad length or start at or past size: result registered straight from idle.
// Free/test/mark read then modify the word; allocate runs a count pass, then a commit pass.
// One item at a time; the next is accepted as the final result goes out; no out stall.
// Reset: a clearing pass writes all DEPTH store words with busy high.
module bitmap_run_allocator_core import bra_pkg::*; #(
  parameter int MAP_BITS  = MAP_BITS_DEF,
  parameter int MAX_RUN   = MAX_RUN_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  start,
  output logic                  busy,
  input  logic [KIND_W-1:0]     in_kind,
  input  logic [INDEX_W-1:0]    in_index,
  input  logic [RUN_W-1:0]      in_run_length,
  // result channel, one item per strobe, cannot be held off
  output logic                  out_valid,
  output logic [STATUS_W-1:0]   out_status,
  output logic [INDEX_W-1:0]    out_bit_index,
  output logic                  out_is_set,
  output logic                  out_last,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH   = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WB_LG   = $clog2(WORD_BITS);
  localparam int CNT_W   = $clog2(WORD_BITS + 1);
  localparam int ACC_W   = $clog2(WORD_BITS + (1 << RUN_W)) + 1;
  localparam int UW      = TOTAL_W;  // unit index width, base regs carry one more bit
  localparam int MAP_CAP = (MAP_BITS < (1 << TOTAL_W) - 1) ? MAP_BITS : (1 << TOTAL_W) - 1;

  // sequencer states
  localparam logic [2:0] S_CLR      = 3'd0;  // clearing pass after reset
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_BMOD     = 3'd2;  // single-bit test or read-modify-write
  localparam logic [2:0] S_CNT_RD   = 3'd3;  // issue first count read
  localparam logic [2:0] S_CNT      = 3'd4;  // count pass, one word per cycle
  localparam logic [2:0] S_ALC_RD   = 3'd5;  // commit pass: read word
  localparam logic [2:0] S_ALC_LD   = 3'd6;  // commit pass: latch word and mask
  localparam logic [2:0] S_ALC_PICK = 3'd7;  // commit pass: one unit per cycle

  logic [2:0]            state_r, state_nxt;
  logic [AW-1:0]         clr_r, clr_nxt;
  logic [TOTAL_W-1:0]    total_bits_r;
  logic [START_W-1:0]    search_start_r;

  logic [KIND_W-1:0]     kind_r, kind_nxt;
  logic [INDEX_W-1:0]    index_r, index_nxt;
  logic [RUN_W-1:0]      want_r, want_nxt;
  logic [RUN_W-1:0]      rem_r, rem_nxt;
  logic [ACC_W-1:0]      cnt_r, cnt_nxt;
  logic [UW:0]           base_r, base_nxt;
  logic [WORD_BITS-1:0]  word_r, word_nxt;
  logic [WORD_BITS-1:0]  mask_r, mask_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [INDEX_W-1:0]    out_bit_index_r, out_bit_index_nxt;
  logic                  out_is_set_r, out_is_set_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [WORD_BITS-1:0]  wr_data;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [WORD_BITS-1:0]  rd_data;

  logic [WORD_BITS-1:0]  free_mask;
  logic [CNT_W-1:0]      free_cnt;

  logic [TOTAL_W-1:0]    size;
  logic [UW:0]           sbase;
  logic [UW:0]           base_step;
  logic [ACC_W-1:0]      cnt_sum;
  logic                  accept;
  logic                  bad_len;
  logic [WORD_BITS-1:0]  bit_sel;
  logic [WORD_BITS-1:0]  lowest;
  logic [WB_LG-1:0]      pick_off;
  logic [UW:0]           pick_unit;
  logic [WORD_BITS-1:0]  mask_left;
  logic [WORD_BITS-1:0]  word_set;

  // word address of a unit index
  function automatic logic [AW-1:0] addr_of(input logic [UW:0] u);
    logic [AW+UW:0] t;
    t = {{AW{1'b0}}, u} >> WB_LG;
    return t[AW-1:0];
  endfunction

  bra_store #(
    .DEPTH (DEPTH),
    .WIDTH (WORD_BITS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // scanner always looks at the word just read and the word base it belongs to
  bra_scan #(
    .WORD_BITS (WORD_BITS)
  ) u_scan (
    .word      (rd_data),
    .base      (base_r),
    .start     (search_start_r),
    .size      (size),
    .free_mask (free_mask),
    .free_cnt  (free_cnt)
  );

  assign cfg_ready = 1'b1;
  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;

  always_comb begin
    // active size saturates at the map size
    size      = (total_bits_r < TOTAL_W'(MAP_CAP)) ? total_bits_r : TOTAL_W'(MAP_CAP);
    sbase     = ((UW + 1)'(search_start_r) >> WB_LG) << WB_LG;
    base_step = base_r + (UW + 1)'(WORD_BITS);
    cnt_sum   = cnt_r + ACC_W'(free_cnt);
    bad_len   = (in_run_length == '0) || (32'(in_run_length) > 32'(MAX_RUN));
    bit_sel   = WORD_BITS'(1) << index_r[WB_LG-1:0];

    // lowest pending free bit of the latched word
    lowest    = mask_r & (~mask_r + WORD_BITS'(1));
    pick_off  = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      if (lowest[j]) begin
        pick_off = pick_off | WB_LG'(j);
      end
    end
    pick_unit = base_r + (UW + 1)'(pick_off);
    mask_left = mask_r & ~lowest;
    word_set  = word_r | lowest;
  end

  always_comb begin
    state_nxt         = state_r;
    clr_nxt           = clr_r;
    kind_nxt          = kind_r;
    index_nxt         = index_r;
    want_nxt          = want_r;
    rem_nxt           = rem_r;
    cnt_nxt           = cnt_r;
    base_nxt          = base_r;
    word_nxt          = word_r;
    mask_nxt          = mask_r;
    out_valid_nxt     = 1'b0;
    out_status_nxt    = out_status_r;
    out_bit_index_nxt = out_bit_index_r;
    out_is_set_nxt    = out_is_set_r;
    out_last_nxt      = out_last_r;
    wr_en             = 1'b0;
    wr_addr           = addr_of(base_r);
    wr_data           = word_set;
    rd_en             = 1'b0;
    rd_addr           = addr_of(base_r);

    unique case (state_r)
      S_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = '0;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          kind_nxt  = in_kind;
          index_nxt = in_index;
          want_nxt  = in_run_length;
          if (in_kind == KIND_ALLOC) begin
            if (bad_len) begin
              out_valid_nxt     = 1'b1;
              out_status_nxt    = ST_RANGE;
              out_bit_index_nxt = '0;
              out_is_set_nxt    = 1'b0;
              out_last_nxt      = 1'b1;
            end else if ({1'b0, search_start_r} >= size) begin
              out_valid_nxt     = 1'b1;
              out_status_nxt    = ST_FULL;
              out_bit_index_nxt = '0;
              out_is_set_nxt    = 1'b0;
              out_last_nxt      = 1'b1;
            end else begin
              base_nxt  = sbase;
              cnt_nxt   = '0;
              state_nxt = S_CNT_RD;
            end
          end else if ((TOTAL_W)'(in_index) >= size) begin
            out_valid_nxt     = 1'b1;
            out_status_nxt    = ST_RANGE;
            out_bit_index_nxt = in_index;
            out_is_set_nxt    = 1'b0;
            out_last_nxt      = 1'b1;
          end else begin
            // single-bit op: read the word now, modify next cycle
            rd_en     = 1'b1;
            rd_addr   = addr_of((UW + 1)'(in_index));
            state_nxt = S_BMOD;
          end
        end
      end

      S_BMOD: begin
        wr_addr           = addr_of((UW + 1)'(index_r));
        out_valid_nxt     = 1'b1;
        out_status_nxt    = ST_OK;
        out_bit_index_nxt = index_r;
        out_last_nxt      = 1'b1;
        state_nxt         = S_IDLE;
        case (kind_r)
          KIND_FREE: begin
            wr_en          = 1'b1;
            wr_data        = rd_data & ~bit_sel;
            out_is_set_nxt = 1'b0;
          end
          KIND_MARK: begin
            wr_en          = 1'b1;
            wr_data        = rd_data | bit_sel;
            out_is_set_nxt = 1'b1;
          end
          default: begin
            out_is_set_nxt = |(rd_data & bit_sel);
          end
        endcase
      end

      S_CNT_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_CNT;
      end

      S_CNT: begin
        // rd_data holds the word at base_r; next word is read speculatively
        cnt_nxt = cnt_sum;
        if (cnt_sum >= ACC_W'(want_r)) begin
          base_nxt  = sbase;
          rem_nxt   = want_r;
          state_nxt = S_ALC_RD;
        end else if (base_step >= {1'b0, size}) begin
          out_valid_nxt     = 1'b1;
          out_status_nxt    = ST_FULL;
          out_bit_index_nxt = '0;
          out_is_set_nxt    = 1'b0;
          out_last_nxt      = 1'b1;
          state_nxt         = S_IDLE;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = addr_of(base_step);
          base_nxt = base_step;
        end
      end

      S_ALC_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_ALC_LD;
      end

      S_ALC_LD: begin
        if (free_mask == '0) begin
          base_nxt  = base_step;
          state_nxt = S_ALC_RD;
        end else begin
          word_nxt  = rd_data;
          mask_nxt  = free_mask;
          state_nxt = S_ALC_PICK;
        end
      end

      S_ALC_PICK: begin
        out_valid_nxt     = 1'b1;
        out_status_nxt    = ST_OK;
        out_bit_index_nxt = pick_unit[INDEX_W-1:0];
        out_is_set_nxt    = 1'b1;
        out_last_nxt      = (rem_r == RUN_W'(1));
        rem_nxt           = rem_r - RUN_W'(1);
        word_nxt          = word_set;
        mask_nxt          = mask_left;
        // write the word back once it is exhausted or the run is complete
        if ((rem_r == RUN_W'(1)) || (mask_left == '0)) begin
          wr_en = 1'b1;
          if (rem_r == RUN_W'(1)) begin
            state_nxt = S_IDLE;
          end else begin
            base_nxt  = base_step;
            state_nxt = S_ALC_RD;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_CLR;
      clr_r          <= '0;
      out_valid_r    <= 1'b0;
      total_bits_r   <= TOTAL_BITS_RST;
      search_start_r <= SEARCH_START_RST;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_TOTAL_BITS:   total_bits_r   <= cfg_data[TOTAL_W-1:0];
          CFG_SEARCH_START: search_start_r <= cfg_data[START_W-1:0];
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    kind_r          <= kind_nxt;
    index_r         <= index_nxt;
    want_r          <= want_nxt;
    rem_r           <= rem_nxt;
    cnt_r           <= cnt_nxt;
    base_r          <= base_nxt;
    word_r          <= word_nxt;
    mask_r          <= mask_nxt;
    out_status_r    <= out_status_nxt;
    out_bit_index_r <= out_bit_index_nxt;
    out_is_set_r    <= out_is_set_nxt;
    out_last_r      <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_bit_index = out_bit_index_r;
  assign out_is_set    = out_is_set_r;
  assign out_last      = out_last_r;

endmodule

[verif/testbench.sv]
// Self-checking testbench for bitmap_run_allocator_core: directed and random
// requests, config changes between phases, every result checked against a predictor.
// Depends on bra_pkg and the bitmap_run_allocator_core RTL.
module testbench;
  import bra_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_LIMIT = 5000;  // cycles allowed for outstanding results
  localparam int SETTLE_CYCLES = 4;   // idle cycles after the last result

  // One result item as it appears on the out_ ports.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  bit_index;
    logic                is_set;
    logic                last;
  } alloc_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [KIND_W-1:0]     in_kind = KIND_TEST;
  logic [INDEX_W-1:0]    in_index = '0;
  logic [RUN_W-1:0]      in_run_length = '0;
  logic                  out_valid;
  logic [STATUS_W-1:0]   out_status;
  logic [INDEX_W-1:0]    out_bit_index;
  logic                  out_is_set;
  logic                  out_last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_TOTAL_BITS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor state: shadow bitmap (1 = used) and shadow registers.
  bit                    used_map [MAP_BITS_DEF];
  logic [TOTAL_W-1:0]    total_reg = TOTAL_BITS_RST;
  logic [START_W-1:0]    start_reg = SEARCH_START_RST;

  alloc_result_t         pending_results [$];
  int                    errors = 0;
  int                    items_sent = 0;
  int                    results_checked = 0;
  int                    reg_writes = 0;
  int                    idle_pct = 0;  // chance in 100 that the sender idles a cycle

  bitmap_run_allocator_core uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_kind       (in_kind),
    .in_index      (in_index),
    .in_run_length (in_run_length),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_bit_index (out_bit_index),
    .out_is_set    (out_is_set),
    .out_last      (out_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Active size saturates at the map size; zero makes every index out of range.
  function automatic int unsigned active_units();
    return (total_reg < MAP_BITS_DEF) ? int'(total_reg) : MAP_BITS_DEF;
  endfunction

  function automatic alloc_result_t make_result(logic [STATUS_W-1:0] st,
                                                logic [INDEX_W-1:0] idx,
                                                logic set, logic fin);
    alloc_result_t r;
    r.status = st;
    r.bit_index = idx;
    r.is_set = set;
    r.last = fin;
    return r;
  endfunction

  // Works out the results of one accepted item and updates the shadow bitmap.
  task automatic predict_request(input logic [KIND_W-1:0] kind,
                                 input logic [INDEX_W-1:0] idx,
                                 input logic [RUN_W-1:0] len);
    int unsigned size;
    int unsigned n;
    int unsigned hits [MAX_RUN_DEF];
    size = active_units();
    n = 0;
    if (kind == KIND_ALLOC) begin
      if (len == 0 || len > MAX_RUN_DEF) begin
        // bad run length: nothing changes
        pending_results.push_back(make_result(ST_RANGE, '0, 1'b0, 1'b1));
      end else begin
        // first fit from the search start; a start at or past size finds nothing
        for (int unsigned i = 32'(start_reg); i < size && n < len; i++) begin
          if (!used_map[i]) begin
            hits[n] = i;
            n++;
          end
        end
        if (n < len) begin
          pending_results.push_back(make_result(ST_FULL, '0, 1'b0, 1'b1));
        end else begin
          for (int unsigned k = 0; k < n; k++) begin
            used_map[hits[k]] = 1'b1;
            pending_results.push_back(make_result(ST_OK, hits[k][INDEX_W-1:0], 1'b1,
                                                  k == n - 1));
          end
        end
      end
    end else if (idx >= size) begin
      pending_results.push_back(make_result(ST_RANGE, idx, 1'b0, 1'b1));
    end else begin
      case (kind)
        KIND_FREE: begin
          used_map[idx] = 1'b0;
          pending_results.push_back(make_result(ST_OK, idx, 1'b0, 1'b1));
        end
        KIND_TEST: begin
          pending_results.push_back(make_result(ST_OK, idx, used_map[idx], 1'b1));
        end
        default: begin
          used_map[idx] = 1'b1;
          pending_results.push_back(make_result(ST_OK, idx, 1'b1, 1'b1));
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: results cannot be held off, so every strobe is taken.
  // Outputs are sampled at the edge, before the block's own updates land.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    alloc_result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d bit_index %0d is_set %0d last %0d",
               out_status, out_bit_index, out_is_set, out_last);
        errors++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          errors++;
        end
        if (out_bit_index !== want.bit_index) begin
          $error("bit_index: expected %0d, got %0d", want.bit_index, out_bit_index);
          errors++;
        end
        if (out_is_set !== want.is_set) begin
          $error("is_set: expected %0d, got %0d", want.is_set, out_is_set);
          errors++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_last);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Sends one item. start stays high on return so a back-to-back item needs
  // only new fields; anything that pauses lowers start itself.
  task automatic send_item(input logic [KIND_W-1:0] kind,
                           input logic [INDEX_W-1:0] idx,
                           input logic [RUN_W-1:0] len);
    // each cycle the sender idles with the phase's chance
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_kind <= kind;
    in_index <= idx;
    in_run_length <= len;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    // accepted at this edge
    predict_request(kind, idx, len);
    items_sent++;
  endtask

  // Stops sending and waits until every expected result is in and the block
  // is idle. Always lets the clock advance after start is lowered.
  task automatic wait_drained();
    int waited;
    start <= 1'b0;
    waited = 0;
    @(posedge clk);
    while ((pending_results.size() != 0 || busy !== 1'b0) && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      errors++;
      pending_results.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_valid high so consecutive writes need no extra NBA on it.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    if (idx == CFG_TOTAL_BITS) begin
      total_reg = data[TOTAL_W-1:0];
    end else begin
      start_reg = data[START_W-1:0];
    end
    reg_writes++;
  endtask

  // Registers change only with the block idle and nothing outstanding.
  task automatic configure(input logic [CFG_DATA_W-1:0] total,
                           input logic [CFG_DATA_W-1:0] search);
    wait_drained();
    write_register(CFG_TOTAL_BITS, total);
    write_register(CFG_SEARCH_START, search);
    cfg_valid <= 1'b0;
  endtask

  // Index mostly inside the searchable window, sometimes anywhere in the field.
  function automatic logic [INDEX_W-1:0] pick_index();
    int unsigned size;
    int unsigned lo;
    size = active_units();
    lo = (start_reg < size) ? int'(start_reg) : 0;
    if (size == 0 || $urandom_range(99) < 15) begin
      return INDEX_W'($urandom_range(MAP_BITS_DEF - 1, 0));
    end
    return INDEX_W'($urandom_range(size - 1, lo));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, all kinds, bad lengths, full, range, zero and oversized size.
  task automatic test_directed();
    idle_pct = 0;
    send_item(KIND_ALLOC, '0, 4'd1);
    send_item(KIND_ALLOC, '1, 4'd8);          // longest run
    send_item(KIND_ALLOC, '0, 4'd0);          // zero length
    send_item(KIND_ALLOC, '0, 4'd15);         // length field all ones
    send_item(KIND_ALLOC, '0, 4'd9);          // just past the longest run
    send_item(KIND_TEST, '1, '0);             // top unit, still free
    send_item(KIND_MARK, '1, '1);
    send_item(KIND_TEST, '1, '0);
    send_item(KIND_FREE, 12'd3, '0);
    send_item(KIND_ALLOC, '0, 4'd2);          // refills the hole, then continues
    send_item(KIND_TEST, 12'd3, '0);
    // small map with search start inside it
    configure(13'd16, 13'd10);
    send_item(KIND_TEST, 12'd16, '0);         // first index past the size
    send_item(KIND_FREE, '1, '0);
    send_item(KIND_ALLOC, '0, 4'd6);          // takes the rest of the window
    send_item(KIND_ALLOC, '0, 4'd1);          // full
    send_item(KIND_FREE, 12'd12, '0);
    send_item(KIND_ALLOC, '0, 4'd1);
    // search start equal to size
    configure(13'd16, 13'd16);
    send_item(KIND_ALLOC, '0, 4'd1);
    // zero size
    configure(13'd0, 13'd0);
    send_item(KIND_TEST, '0, '0);
    send_item(KIND_ALLOC, '0, 4'd1);
    // oversized size saturates, search start at the top unit
    configure(13'h1FFF, 13'd4095);
    send_item(KIND_TEST, '1, '0);
    send_item(KIND_FREE, '1, '0);
    send_item(KIND_ALLOC, '0, 4'd1);
    send_item(KIND_ALLOC, '0, 4'd1);
  endtask

  // Random mix under one register setting and one idling pattern.
  task automatic test_random_traffic(input logic [CFG_DATA_W-1:0] total,
                                     input logic [CFG_DATA_W-1:0] search,
                                     input int pct, input int count);
    int unsigned roll;
    int unsigned v;
    logic [KIND_W-1:0] kind;
    logic [RUN_W-1:0] len;
    configure(total, search);
    idle_pct = pct;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 40) kind = KIND_ALLOC;
      else if (roll < 65) kind = KIND_FREE;
      else if (roll < 82) kind = KIND_TEST;
      else kind = KIND_MARK;
      if (kind == KIND_ALLOC) begin
        if ($urandom_range(99) < 6) begin
          v = $urandom_range(7);
          len = (v == 0) ? 4'd0 : 4'(8 + v);  // 0 or 9..15
        end else begin
          len = RUN_W'($urandom_range(MAX_RUN_DEF, 1));
        end
        send_item(kind, INDEX_W'($urandom_range(MAP_BITS_DEF - 1, 0)), len);
      end else begin
        send_item(kind, pick_index(), RUN_W'($urandom_range(15)));
      end
    end
    idle_pct = 0;
  endtask

  // Sender holds off until everything in flight has come back, item by item.
  task automatic test_pause_until_drained();
    configure(13'd64, 13'd0);
    idle_pct = 0;
    for (int n = 0; n < 4; n++) begin
      send_item(KIND_ALLOC, '0, RUN_W'($urandom_range(MAX_RUN_DEF, 1)));
      wait_drained();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // the block clears its store after reset with busy high
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);

    test_directed();
    test_pause_until_drained();
    test_random_traffic(13'd64, 13'd0, 0, 35);
    test_random_traffic(13'd100, 13'd37, 49, 35);
    test_random_traffic(13'h1FFF, 13'd4090, 16, 30);
    test_random_traffic(13'd1, 13'd0, 49, 20);
    test_random_traffic(13'd300, 13'd200, 16, 40);
    test_random_traffic(13'd4096, 13'd0, 0, 40);
    wait_drained();

    $display("Checked %0d results from %0d requests, with %0d register writes.",
             results_checked, items_sent, reg_writes);
    $display("Covered alloc/free/test/mark, full, out-of-range and bad-length cases.");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #10ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
